@@ sv/brrb_pkg.sv @@
`default_nettype none

package brrb_pkg;

    // Default geometry of the banked stores
    localparam int BANK_COUNT_DEF = 32;
    localparam int BANK_BYTES_DEF = 16384;

    // Width of the computed bank number (active + 8 + (255 - 1) * 4 = 1028)
    localparam int CALC_BANK_W = 11;

    // Transaction kinds
    typedef enum logic [2:0] {
        KIND_REG_READ  = 3'd0,
        KIND_REG_WRITE = 3'd1,
        KIND_MEM_READ  = 3'd2,
        KIND_MEM_WRITE = 3'd3,
        KIND_PRELOAD   = 3'd4
    } kind_t;

    // Register map
    localparam logic [15:0] ADDR_PORT_B_OUT = 16'h0320;
    localparam logic [15:0] ADDR_PORT_A_OUT = 16'h0321;
    localparam logic [15:0] ADDR_PORT_B_DIR = 16'h0322;
    localparam logic [15:0] ADDR_PORT_A_DIR = 16'h0323;
    localparam logic [15:0] ADDR_CONTROL    = 16'h0342;
    localparam logic [15:0] ADDR_BANK_SET   = 16'h0343;
    localparam logic [15:0] ADDR_OVERLAY    = 16'h0314;

    // Reset values
    localparam logic [7:0] PORT_A_OUT_RST  = 8'h07;
    localparam logic [7:0] PORT_A_DIR_RST  = 8'b1010_0111;
    localparam logic [7:0] PORT_B_OUT_RST  = 8'h00;
    localparam logic [7:0] PORT_B_DIR_RST  = 8'b1100_0000;
    localparam logic [7:0] CONTROL_BASE    = 8'(128 + 1);
    localparam logic [7:0] BANK_SET_RST    = 8'h00;
    localparam logic [2:0] ACTIVE_BANK_RST = 3'd7;
    localparam logic [1:0] FW_VERSION_RST  = 2'd1;

    // Firmware mode with the overlay mirror
    localparam logic [1:0] FW_OVERLAY = 2'd2;

    // Control bit that maps RAM into banks 1..4
    localparam int CTRL_RAM_BIT = 5;

    // Result waiting for the memory read data
    typedef struct packed {
        logic       use_mem;
        logic       use_ram;
        logic [7:0] rd;
        logic       fault;
    } pend_t;

    // Port write with direction masking and optional input merge
    function automatic logic [7:0] port_write(input logic [7:0] old_val,
                                              input logic [7:0] dir,
                                              input logic [7:0] val,
                                              input logic       merge);
        logic [7:0] res;
        if (merge)
            res = (old_val & dir) | (val & ~dir);
        else
            res = val & dir;
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/banked_rom_ram_board_with_ports.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    kind, address, data, port_mode,
//                                             load_bank, load_is_ram
// result    out        out_valid / out_ready  read_data, bank_fault
// config    in         cfg_we                 cfg_wdata (firmware mode)
//
// One transaction per cycle unless the output stalls: register state and store
// writes settle at the accepting edge, where a store read is also captured from
// the synchronous RAM or ROM array while its entry enters a pending stage ahead
// of the output register. Results leave in order through the pending stage and
// then the output register.
// With the output stalled, one more transaction is taken into the pending
// stage, then in_ready drops. Reset clears control state; stores are not
// cleared and hold undefined data until written.

module banked_rom_ram_board_with_ports #(
    parameter int BANK_COUNT = brrb_pkg::BANK_COUNT_DEF,
    parameter int BANK_BYTES = brrb_pkg::BANK_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  kind,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  data,
    input  wire logic        port_mode,
    input  wire logic [4:0]  load_bank,
    input  wire logic        load_is_ram,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       read_data,
    output logic             bank_fault
);

    localparam int MEM_DEPTH = BANK_COUNT * BANK_BYTES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int BIDX_W    = $clog2(BANK_COUNT);
    localparam int CBW       = brrb_pkg::CALC_BANK_W;

    // Board registers
    logic [1:0] fw_reg,          fw_next;
    logic [7:0] port_a_out_reg,  port_a_out_next;
    logic [7:0] port_a_dir_reg,  port_a_dir_next;
    logic [7:0] port_b_out_reg,  port_b_out_next;
    logic [7:0] port_b_dir_reg,  port_b_dir_next;
    logic [7:0] control_reg,     control_next;
    logic [7:0] bank_set_reg,    bank_set_next;
    logic [2:0] active_bank_reg, active_bank_next;

    // Pending and output stages
    logic            pend_valid_reg, pend_valid_next;
    brrb_pkg::pend_t pend_reg,       pend_next;
    logic            out_valid_reg,  out_valid_next;
    logic [7:0]      out_rd_reg;
    logic            out_fault_reg;

    // Stores
    logic [7:0] ram_mem [MEM_DEPTH];
    logic [7:0] rom_mem [MEM_DEPTH];
    logic [7:0] ram_q_reg;
    logic [7:0] rom_q_reg;

    logic              in_fire;
    logic              pend_move;
    brrb_pkg::kind_t   kind_dec;
    logic [CBW-1:0]    calc_bank;
    logic              calc_ram;
    logic [CBW-1:0]    tgt_bank;
    logic              offset_ok;
    logic [MEM_AW-1:0] mem_addr;
    logic              ram_we;
    logic              rom_we;
    logic              ram_re;
    logic              rom_re;
    logic [7:0]        pend_data;

    // Handshake between stages
    assign pend_move = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pend_valid_reg || pend_move;
    assign in_fire   = in_valid && in_ready;
    assign kind_dec  = brrb_pkg::kind_t'(kind);

    // Compute the bank for a bus memory access
    always_comb
    begin
        if (active_bank_reg == 3'd0)
        begin
            calc_bank = '0;
            calc_ram  = 1'b1;
        end
        else
        begin
            if (active_bank_reg < 3'd5 && bank_set_reg != 8'd0)
                calc_bank = CBW'(active_bank_reg) + CBW'(8)
                          + ((CBW'(bank_set_reg) - CBW'(1)) << 2);
            else
                calc_bank = CBW'(active_bank_reg);
            calc_ram = control_reg[brrb_pkg::CTRL_RAM_BIT] && (active_bank_reg < 3'd5);
        end
    end

    // Form the store index
    assign tgt_bank  = (kind_dec == brrb_pkg::KIND_PRELOAD) ? CBW'(load_bank) : calc_bank;
    assign offset_ok = {1'b0, address} < 17'(BANK_BYTES);
    assign mem_addr  = MEM_AW'(tgt_bank[BIDX_W-1:0]) * MEM_AW'(BANK_BYTES)
                     + MEM_AW'(address);

    // Decode the transaction
    always_comb
    begin
        fw_next          = fw_reg;
        port_a_out_next  = port_a_out_reg;
        port_a_dir_next  = port_a_dir_reg;
        port_b_out_next  = port_b_out_reg;
        port_b_dir_next  = port_b_dir_reg;
        control_next     = control_reg;
        bank_set_next    = bank_set_reg;
        active_bank_next = active_bank_reg;
        ram_we           = 1'b0;
        rom_we           = 1'b0;
        ram_re           = 1'b0;
        rom_re           = 1'b0;
        pend_next        = '0;

        unique case (kind_dec)
            brrb_pkg::KIND_REG_READ:
            begin
                unique case (address)
                    brrb_pkg::ADDR_CONTROL:    pend_next.rd = control_reg;
                    brrb_pkg::ADDR_PORT_A_DIR: pend_next.rd = port_a_dir_reg;
                    brrb_pkg::ADDR_PORT_A_OUT: pend_next.rd = port_a_out_reg;
                    brrb_pkg::ADDR_PORT_B_DIR: pend_next.rd = port_b_dir_reg;
                    brrb_pkg::ADDR_PORT_B_OUT: pend_next.rd = port_b_out_reg;
                    brrb_pkg::ADDR_BANK_SET:   pend_next.rd = bank_set_reg;
                    default:                   pend_next.rd = 8'd0;
                endcase
            end
            brrb_pkg::KIND_REG_WRITE:
            begin
                unique case (address)
                    brrb_pkg::ADDR_PORT_A_DIR: port_a_dir_next = data;
                    brrb_pkg::ADDR_PORT_A_OUT:
                    begin
                        port_a_out_next  = brrb_pkg::port_write(port_a_out_reg,
                                               port_a_dir_reg, data, port_mode);
                        active_bank_next = port_a_out_next[2:0];
                    end
                    brrb_pkg::ADDR_PORT_B_DIR: port_b_dir_next = data;
                    brrb_pkg::ADDR_PORT_B_OUT:
                        port_b_out_next = brrb_pkg::port_write(port_b_out_reg,
                                              port_b_dir_reg, data, port_mode);
                    brrb_pkg::ADDR_CONTROL:    control_next  = data;
                    brrb_pkg::ADDR_BANK_SET:   bank_set_next = data;
                    brrb_pkg::ADDR_OVERLAY:
                    begin
                        if (fw_reg == brrb_pkg::FW_OVERLAY)
                            active_bank_next = data[1] ? 3'd6 : 3'd0;
                    end
                    default: ;
                endcase
            end
            brrb_pkg::KIND_MEM_READ, brrb_pkg::KIND_MEM_WRITE:
            begin
                if (calc_bank >= CBW'(BANK_COUNT))
                    pend_next.fault = 1'b1;
                else if (offset_ok)
                begin
                    if (kind_dec == brrb_pkg::KIND_MEM_READ)
                    begin
                        pend_next.use_mem = 1'b1;
                        pend_next.use_ram = calc_ram;
                        ram_re            = calc_ram;
                        rom_re            = !calc_ram;
                    end
                    else
                        ram_we = calc_ram;
                end
            end
            brrb_pkg::KIND_PRELOAD:
            begin
                if (CBW'(load_bank) >= CBW'(BANK_COUNT))
                    pend_next.fault = 1'b1;
                else if (offset_ok)
                begin
                    ram_we = load_is_ram;
                    rom_we = !load_is_ram;
                end
            end
            default: ;
        endcase

        // Apply a configuration write
        if (cfg_we)
        begin
            fw_next      = cfg_wdata;
            control_next = control_reg | {6'd0, cfg_wdata};
        end
    end

    // Hold the board registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg          <= brrb_pkg::FW_VERSION_RST;
            port_a_out_reg  <= brrb_pkg::PORT_A_OUT_RST;
            port_a_dir_reg  <= brrb_pkg::PORT_A_DIR_RST;
            port_b_out_reg  <= brrb_pkg::PORT_B_OUT_RST;
            port_b_dir_reg  <= brrb_pkg::PORT_B_DIR_RST;
            control_reg     <= brrb_pkg::CONTROL_BASE | {6'd0, brrb_pkg::FW_VERSION_RST};
            bank_set_reg    <= brrb_pkg::BANK_SET_RST;
            active_bank_reg <= brrb_pkg::ACTIVE_BANK_RST;
        end
        else if (in_fire || cfg_we)
        begin
            fw_reg          <= fw_next;
            port_a_out_reg  <= port_a_out_next;
            port_a_dir_reg  <= port_a_dir_next;
            port_b_out_reg  <= port_b_out_next;
            port_b_dir_reg  <= port_b_dir_next;
            control_reg     <= control_next;
            bank_set_reg    <= bank_set_next;
            active_bank_reg <= active_bank_next;
        end
    end

    // Access the RAM store
    always_ff @(posedge clk)
    begin
        if (in_fire && ram_we)
            ram_mem[mem_addr] <= data;
        if (in_fire && ram_re)
            ram_q_reg <= ram_mem[mem_addr];
    end

    // Access the ROM store
    always_ff @(posedge clk)
    begin
        if (in_fire && rom_we)
            rom_mem[mem_addr] <= data;
        if (in_fire && rom_re)
            rom_q_reg <= rom_mem[mem_addr];
    end

    // Advance the pending and output stages
    always_comb
    begin
        if (in_fire)
            pend_valid_next = 1'b1;
        else if (pend_move)
            pend_valid_next = 1'b0;
        else
            pend_valid_next = pend_valid_reg;

        if (pend_move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Select the read byte once store data has arrived
    assign pend_data = pend_reg.use_mem ? (pend_reg.use_ram ? ram_q_reg : rom_q_reg)
                                        : pend_reg.rd;

    always_ff @(posedge clk)
    begin
        if (in_fire)
            pend_reg <= pend_next;
        if (pend_move)
        begin
            out_rd_reg    <= pend_data;
            out_fault_reg <= pend_reg.fault;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = out_rd_reg;
    assign bank_fault = out_fault_reg;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
module tb;

    localparam int BANKS       = brrb_pkg::BANK_COUNT_DEF;
    localparam int BYTES       = brrb_pkg::BANK_BYTES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 155;
    localparam int PHASES      = 6;

    // Highest code the kind field can carry; codes above preload do nothing
    localparam logic [2:0] KIND_LAST = 3'd7;

    // One bus transaction with the reply the board owes for it
    typedef struct {
        logic [2:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        mode;
        logic [4:0]  lbank;
        logic        lram;
        logic [7:0]  rd;
        logic        fault;
    } bus_xact_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  kind = 3'd0;
    logic [15:0] address = 16'd0;
    logic [7:0]  data = 8'd0;
    logic        port_mode = 1'b0;
    logic [4:0]  load_bank = 5'd0;
    logic        load_is_ram = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  read_data;
    logic        bank_fault;

    // Board state as the bus sees it
    logic [1:0]  fw_mode;
    logic [7:0]  pa_out;
    logic [7:0]  pa_dir;
    logic [7:0]  pb_out;
    logic [7:0]  pb_dir;
    logic [7:0]  ctrl;
    logic [7:0]  bank_set;
    logic [2:0]  act_bank;
    logic [7:0]  store_img [int];
    int          written_keys [$];

    bus_xact_t   access_q [$];
    bus_xact_t   reply_q [$];
    bus_xact_t   cur;
    logic [1:0]  fw_seq [0:PHASES-1];

    int n_made = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_hits = 0;
    int n_faults = 0;
    int n_overlay = 0;
    int cycle_cnt = 0;
    int in_gap = 0;
    int out_gap = 0;
    int idle_odds = 0;

    banked_rom_ram_board_with_ports #(
        .BANK_COUNT (BANKS),
        .BANK_BYTES (BYTES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .address     (address),
        .data        (data),
        .port_mode   (port_mode),
        .load_bank   (load_bank),
        .load_is_ram (load_is_ram),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .bank_fault  (bank_fault)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reset values of the board registers
    function automatic void board_reset();
        fw_mode  = 2'd1;
        pa_out   = 8'h07;
        pa_dir   = 8'hA7;
        pb_out   = 8'h00;
        pb_dir   = 8'hC0;
        ctrl     = 8'h81 | {6'd0, fw_mode};
        bank_set = 8'h00;
        act_bank = 3'd7;
    endfunction

    // Bank a memory access reaches; to_ram tells RAM from ROM
    function automatic int map_bank(output bit to_ram);
        to_ram = 1'b1;
        if (act_bank == 3'd0)
            return 0;
        // control bit 5 maps RAM into banks 1..4
        to_ram = ctrl[5] && act_bank < 3'd5;
        if (act_bank < 3'd5 && bank_set != 8'd0)
            return int'(act_bank) + 8 + (int'(bank_set) - 1) * 4;
        return int'(act_bank);
    endfunction

    function automatic int store_key(bit to_ram, int bank, logic [15:0] off);
        return (to_ram ? BANKS * BYTES : 0) + bank * BYTES + int'(off);
    endfunction

    function automatic void put_byte(int key, logic [7:0] val);
        if (!store_img.exists(key))
            written_keys.push_back(key);
        store_img[key] = val;
    endfunction

    // Apply one transaction to the board state and fill in its reply
    function automatic bus_xact_t board_access(bus_xact_t a);
        int bank;
        bit to_ram;
        int key;
        a.rd = 8'h00;
        a.fault = 1'b0;
        case (a.kind)
            brrb_pkg::KIND_REG_READ:
                case (a.addr)
                    brrb_pkg::ADDR_CONTROL:    a.rd = ctrl;
                    brrb_pkg::ADDR_PORT_A_DIR: a.rd = pa_dir;
                    brrb_pkg::ADDR_PORT_A_OUT: a.rd = pa_out;
                    brrb_pkg::ADDR_PORT_B_DIR: a.rd = pb_dir;
                    brrb_pkg::ADDR_PORT_B_OUT: a.rd = pb_out;
                    brrb_pkg::ADDR_BANK_SET:   a.rd = bank_set;
                    default:                   a.rd = 8'h00;
                endcase
            brrb_pkg::KIND_REG_WRITE:
                case (a.addr)
                    brrb_pkg::ADDR_PORT_A_DIR: pa_dir = a.data;
                    brrb_pkg::ADDR_PORT_A_OUT:
                    begin
                        // in port mode keep output bits and merge input bits; else mask by direction
                        pa_out = a.mode ? ((pa_out & pa_dir) | (a.data & ~pa_dir))
                                        : (a.data & pa_dir);
                        act_bank = pa_out[2:0];
                    end
                    brrb_pkg::ADDR_PORT_B_DIR: pb_dir = a.data;
                    brrb_pkg::ADDR_PORT_B_OUT:
                        pb_out = a.mode ? ((pb_out & pb_dir) | (a.data & ~pb_dir))
                                        : (a.data & pb_dir);
                    brrb_pkg::ADDR_CONTROL:    ctrl = a.data;
                    brrb_pkg::ADDR_BANK_SET:   bank_set = a.data;
                    brrb_pkg::ADDR_OVERLAY:
                        if (fw_mode == brrb_pkg::FW_OVERLAY)
                        begin
                            act_bank = a.data[1] ? 3'd6 : 3'd0;
                            n_overlay++;
                        end
                    default: ;
                endcase
            brrb_pkg::KIND_MEM_READ, brrb_pkg::KIND_MEM_WRITE:
            begin
                bank = map_bank(to_ram);
                if (bank >= BANKS)
                    a.fault = 1'b1;
                else if (int'(a.addr) < BYTES)
                begin
                    key = store_key(to_ram, bank, a.addr);
                    if (a.kind == brrb_pkg::KIND_MEM_READ)
                    begin
                        a.rd = store_img[key];
                        n_hits++;
                    end
                    else if (to_ram)
                        put_byte(key, a.data);
                end
            end
            brrb_pkg::KIND_PRELOAD:
                if (int'(a.lbank) >= BANKS)
                    a.fault = 1'b1;
                else if (int'(a.addr) < BYTES)
                    put_byte(store_key(a.lram, int'(a.lbank), a.addr), a.data);
            default: ;
        endcase
        if (a.fault)
            n_faults++;
        return a;
    endfunction

    // Predict one transaction and hand it to the driver
    function automatic void queue_access(logic [2:0] k, logic [15:0] addr, logic [7:0] d,
                                         logic m, logic [4:0] lb, logic lr);
        bus_xact_t a;
        int bank;
        bit to_ram;
        int offs [$];
        a.kind  = k;
        a.addr  = addr;
        a.data  = d;
        a.mode  = m;
        a.lbank = lb;
        a.lram  = lr;
        // steer reads away from bytes that were never written
        if (k == brrb_pkg::KIND_MEM_READ)
        begin
            bank = map_bank(to_ram);
            if (bank < BANKS && int'(addr) < BYTES
                && !store_img.exists(store_key(to_ram, bank, addr)))
            begin
                foreach (written_keys[i])
                    if (written_keys[i] / BYTES == (to_ram ? BANKS : 0) + bank)
                        offs.push_back(written_keys[i] % BYTES);
                if (offs.size() > 0)
                    a.addr = 16'(offs[$urandom_range(0, offs.size() - 1)]);
                else
                    a.addr = 16'($urandom_range(BYTES, 16'hFFFF));
            end
        end
        access_q.push_back(board_access(a));
        n_made++;
    endfunction

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom_range(BYTES - 4, BYTES - 1));
            1:       return 16'($urandom);
            2:       return 16'($urandom_range(0, BYTES - 1));
            default: return 16'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [15:0] pick_reg();
        case ($urandom_range(0, 9))
            0, 1, 2: return brrb_pkg::ADDR_PORT_A_OUT;
            3:       return brrb_pkg::ADDR_PORT_A_DIR;
            4:       return brrb_pkg::ADDR_PORT_B_OUT;
            5:       return brrb_pkg::ADDR_PORT_B_DIR;
            6:       return brrb_pkg::ADDR_CONTROL;
            7:       return brrb_pkg::ADDR_BANK_SET;
            8:       return brrb_pkg::ADDR_OVERLAY;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random transaction, weighted toward bank setup and memory traffic
    function automatic void make_access();
        int          r;
        int          bank;
        bit          to_ram;
        logic [2:0]  k;
        logic [15:0] addr;
        logic [7:0]  d;
        logic [4:0]  lb;
        logic        lr;
        r    = $urandom_range(0, 99);
        addr = pick_offset();
        d    = 8'($urandom);
        lb   = 5'($urandom);
        lr   = 1'($urandom);
        if (r < 12)
        begin
            k = brrb_pkg::KIND_PRELOAD;
            // aim most preloads at the bank the bus currently reaches
            bank = map_bank(to_ram);
            if (bank < BANKS && $urandom_range(0, 3) != 0)
            begin
                lb = 5'(bank);
                lr = to_ram;
            end
        end
        else if (r < 37)
            k = brrb_pkg::KIND_MEM_WRITE;
        else if (r < 67)
            k = brrb_pkg::KIND_MEM_READ;
        else if (r < 87)
        begin
            k = brrb_pkg::KIND_REG_WRITE;
            addr = pick_reg();
            if (addr == brrb_pkg::ADDR_PORT_A_DIR && $urandom_range(0, 3) != 0)
                d[2:0] = 3'b111;
            if (addr == brrb_pkg::ADDR_BANK_SET)
                case ($urandom_range(0, 6))
                    0, 1, 2: d = 8'd0;
                    3, 4, 5: d = 8'($urandom_range(1, 6));
                    default: ;
                endcase
        end
        else if (r < 95)
        begin
            k = brrb_pkg::KIND_REG_READ;
            addr = pick_reg();
        end
        else
        begin
            // noise: unused kinds and stray register addresses
            addr = 16'($urandom);
            if ($urandom_range(0, 1) == 0)
                k = 3'($urandom_range(int'(brrb_pkg::KIND_PRELOAD) + 1, int'(KIND_LAST)));
            else
                k = $urandom_range(0, 1) == 0 ? brrb_pkg::KIND_REG_READ
                                              : brrb_pkg::KIND_REG_WRITE;
        end
        queue_access(k, addr, d, 1'($urandom), lb, lr);
    endfunction

    task automatic directed_accesses();
        // register reads from reset and an unmapped address
        queue_access(brrb_pkg::KIND_REG_READ, brrb_pkg::ADDR_CONTROL,
                     8'h00, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_REG_READ, brrb_pkg::ADDR_PORT_A_OUT,
                     8'h00, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_REG_READ, 16'hFFFF, 8'h00, 1'b0, 5'd0, 1'b0);
        // ROM bank 7 is active after reset: load both ends, read back
        queue_access(brrb_pkg::KIND_PRELOAD, 16'd0, 8'hFF, 1'b0, 5'd7, 1'b0);
        queue_access(brrb_pkg::KIND_PRELOAD, 16'(BYTES - 1), 8'h00, 1'b0, 5'd7, 1'b0);
        queue_access(brrb_pkg::KIND_MEM_READ, 16'd0, 8'h00, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_MEM_READ, 16'(BYTES - 1), 8'h00, 1'b0, 5'd0, 1'b0);
        // ROM ignores bus writes
        queue_access(brrb_pkg::KIND_MEM_WRITE, 16'd0, 8'h55, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_MEM_READ, 16'd0, 8'h00, 1'b0, 5'd0, 1'b0);
        // offsets past the bank
        queue_access(brrb_pkg::KIND_MEM_READ, 16'hFFFF, 8'h00, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_PRELOAD, 16'hFFFF, 8'hFF, 1'b1, 5'd31, 1'b1);
        // overlay mirror does nothing outside mode 2
        queue_access(brrb_pkg::KIND_REG_WRITE, brrb_pkg::ADDR_OVERLAY,
                     8'hFF, 1'b0, 5'd0, 1'b0);
        // port A write masked by direction selects bank 0, which is always RAM
        queue_access(brrb_pkg::KIND_REG_WRITE, brrb_pkg::ADDR_PORT_A_DIR,
                     8'h07, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_REG_WRITE, brrb_pkg::ADDR_PORT_A_OUT,
                     8'hF8, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_MEM_WRITE, 16'd5, 8'hA5, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_MEM_READ, 16'd5, 8'h00, 1'b0, 5'd0, 1'b0);
        // bank 4 with the largest bank set runs past the bank count
        queue_access(brrb_pkg::KIND_REG_WRITE, brrb_pkg::ADDR_PORT_A_OUT,
                     8'h04, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_REG_WRITE, brrb_pkg::ADDR_BANK_SET,
                     8'hFF, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_MEM_READ, 16'd0, 8'h00, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_MEM_WRITE, 16'd0, 8'h11, 1'b0, 5'd0, 1'b0);
        // RAM mapping with bank set 1 lands on bank 12
        queue_access(brrb_pkg::KIND_REG_WRITE, brrb_pkg::ADDR_CONTROL,
                     8'h20, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_REG_WRITE, brrb_pkg::ADDR_BANK_SET,
                     8'h01, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_PRELOAD, 16'd3, 8'h3C, 1'b0, 5'd12, 1'b1);
        queue_access(brrb_pkg::KIND_MEM_READ, 16'd3, 8'h00, 1'b0, 5'd0, 1'b0);
        // port B masking and merge
        queue_access(brrb_pkg::KIND_REG_WRITE, brrb_pkg::ADDR_PORT_B_DIR,
                     8'h0F, 1'b0, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_REG_WRITE, brrb_pkg::ADDR_PORT_B_OUT,
                     8'hA0, 1'b1, 5'd0, 1'b0);
        queue_access(brrb_pkg::KIND_REG_READ, brrb_pkg::ADDR_PORT_B_OUT,
                     8'h00, 1'b0, 5'd0, 1'b0);
        queue_access(KIND_LAST, 16'h0321, 8'hFF, 1'b1, 5'd31, 1'b1);
    endtask

    // Wait until every reply is in, then let the pipeline drain
    task automatic wait_idle();
        while (n_checked != n_made)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_firmware(logic [1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        fw_mode = v;
        ctrl = ctrl | {6'd0, v};
    endtask

    // Drive input transactions; hold the payload until accepted
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                reply_q.push_back(cur);
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (access_q.size() > 0)
            begin
                cur = access_q.pop_front();
                kind        <= cur.kind;
                address     <= cur.addr;
                data        <= cur.data;
                port_mode   <= cur.mode;
                load_bank   <= cur.lbank;
                load_is_ram <= cur.lram;
                in_valid    <= 1'b1;
                if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                    in_gap = $urandom_range(1, 11);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Check each reply against the oldest prediction; stall at random
    always @(posedge clk)
    begin
        bus_xact_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (reply_q.size() == 0)
                begin
                    $display("%0t: reply with no transaction pending: read_data %h bank_fault %b",
                             $time, read_data, bank_fault);
                    n_errors++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    n_checked++;
                    if (read_data !== want.rd)
                    begin
                        $display("%0t: read_data (kind %0d addr %h) expected %h actual %h",
                                 $time, want.kind, want.addr, want.rd, read_data);
                        n_errors++;
                    end
                    if (bank_fault !== want.fault)
                    begin
                        $display("%0t: bank_fault (kind %0d addr %h) expected %b actual %b",
                                 $time, want.kind, want.addr, want.fault, bank_fault);
                        n_errors++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                    out_gap = $urandom_range(1, 11);
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d of %0d replies checked",
                     $time, n_checked, n_made);
            $display("** banked_rom_ram_board_with_ports: FAILED **");
            $finish;
        end
    end

    initial
    begin
        fw_seq = '{2'd1, brrb_pkg::FW_OVERLAY, 2'd3, 2'd0, brrb_pkg::FW_OVERLAY, 2'd1};
        board_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            set_firmware(fw_seq[p]);
            // no idling in the final phase
            idle_odds = (p == PHASES - 1) ? 0 : ((p % 2 == 0) ? 5 : 14);
            if (p == 0)
                directed_accesses();
            repeat (PHASE_ITEMS) make_access();
        end
        wait_idle();
        $display("Covered %0d bus transactions over firmware modes 1, 2, 3 and 0.", n_made);
        $display("%0d store reads, %0d bank faults, %0d overlay switches, %0d mismatches.",
                 n_hits, n_faults, n_overlay, n_errors);
        if (n_errors == 0)
            $display("** banked_rom_ram_board_with_ports: PASSED **");
        else
            $display("** banked_rom_ram_board_with_ports: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/brrb_pkg.sv
sv/banked_rom_ram_board_with_ports.sv
sim/tb.sv
